>>> rtl/core/hxp_pkg.sv
// hxp_pkg: character codes and the character class record for the hex text parser
// no dependencies; used by hxp_char_class and hex_text_to_byte_parser_core
package hxp_pkg;

    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    // nibble is only meaningful when is_digit is set
    typedef struct packed {
        logic       is_zero;
        logic       is_x;
        logic       is_sep;
        logic       is_digit;
        logic [3:0] nibble;
    } char_class_t;

endpackage

>>> rtl/core/hxp_char_class.sv
// hxp_char_class: sorts one ascii character into zero, x, separator or hex digit
// depends on hxp_pkg
module hxp_char_class (
    input  logic [7:0]          char_code,
    output hxp_pkg::char_class_t cls
);
    import hxp_pkg::*;

    logic       dec_digit;
    logic       upper_digit;
    logic       lower_digit;
    logic [7:0] offset;

    always_comb
    begin
        dec_digit   = (char_code > CH_0) && (char_code <= CH_9);
        upper_digit = (char_code >= CH_UA) && (char_code <= CH_UF);
        lower_digit = (char_code >= CH_LA) && (char_code <= CH_LF);
        offset      = 8'h00;
        if (dec_digit)
        begin
            offset = char_code - CH_0;
        end
        else if (upper_digit)
        begin
            offset = char_code - CH_UA + 8'd10;
        end
        else if (lower_digit)
        begin
            offset = char_code - CH_LA + 8'd10;
        end
        cls.is_zero  = (char_code == CH_0);
        cls.is_x     = (char_code == CH_X);
        cls.is_sep   = (char_code == CH_SPACE) || (char_code == CH_COMMA) ||
                       (char_code == CH_NL);
        cls.is_digit = dec_digit || upper_digit || lower_digit;
        cls.nibble   = offset[3:0];
    end

endmodule

>>> rtl/core/hex_text_to_byte_parser_core.sv
// hex_text_to_byte_parser_core: packs hex digit text into bytes, one character per cycle while s_tready is high
// depends on hxp_pkg and hxp_char_class
//
//  channel  | dir | tdata          | tuser                        | tlast
//  s_*      | in  | char_code      | -                            | end_of_text
//  m_*      | out | byte_value     | has_byte, bad_character      | text_done
//
// one character per cycle while s_tready is high: classifier and nibble logic
// sit between the input, the parser state and the output register
// a character that gives no result (separator, held zero, x prefix) only updates state
// s_tready is low only while the output register holds a transaction m_tready has not taken
// rst_n clears the parser state and the output valid flag
module hex_text_to_byte_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_value
    output logic [1:0] m_tuser,   // [0] has_byte, [1] bad_character
    output logic       m_tlast    // text_done
);
    import hxp_pkg::*;

    char_class_t cls;

    logic       zero_held_reg,  zero_held_next;
    logic       hn_valid_reg,   hn_valid_next;
    logic [3:0] hn_reg,         hn_next;
    logic       halted_reg,     halted_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_has_reg;
    logic       out_bad_reg;
    logic       out_done_reg;

    logic       got;
    logic       bad;
    logic       consumed;
    logic       emit;
    logic [7:0] byte_val;
    logic       in_fire;

    hxp_char_class u_class (
        .char_code (s_tdata),
        .cls       (cls)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        zero_held_next = zero_held_reg;
        hn_valid_next  = hn_valid_reg;
        hn_next        = hn_reg;
        halted_next    = halted_reg;
        got            = 1'b0;
        bad            = 1'b0;
        consumed       = 1'b0;
        byte_val       = 8'h00;
        if (!halted_reg)
        begin
            // a held zero either pairs with x as a prefix or becomes a digit
            if (zero_held_reg)
            begin
                zero_held_next = 1'b0;
                if (cls.is_x)
                begin
                    consumed = 1'b1;
                end
                else if (hn_valid_next)
                begin
                    byte_val      = {hn_next, 4'h0};
                    got           = 1'b1;
                    hn_valid_next = 1'b0;
                    hn_next       = 4'h0;
                end
                else
                begin
                    hn_next       = 4'h0;
                    hn_valid_next = 1'b1;
                end
            end
            if (!consumed)
            begin
                if (cls.is_zero)
                begin
                    zero_held_next = 1'b1;
                end
                else if (cls.is_digit)
                begin
                    if (hn_valid_next)
                    begin
                        byte_val      = {hn_next, cls.nibble};
                        got           = 1'b1;
                        hn_valid_next = 1'b0;
                        hn_next       = 4'h0;
                    end
                    else
                    begin
                        hn_next       = cls.nibble;
                        hn_valid_next = 1'b1;
                    end
                end
                else if (!cls.is_sep)
                begin
                    bad            = 1'b1;
                    halted_next    = 1'b1;
                    zero_held_next = 1'b0;
                    hn_valid_next  = 1'b0;
                    hn_next        = 4'h0;
                end
            end
        end
        if (s_tlast)
        begin
            // flush a held zero, drop an unpaired nibble, rearm
            if (!halted_next && zero_held_next && hn_valid_next)
            begin
                byte_val = {hn_next, 4'h0};
                got      = 1'b1;
            end
            zero_held_next = 1'b0;
            hn_valid_next  = 1'b0;
            hn_next        = 4'h0;
            halted_next    = 1'b0;
        end
        emit = got || bad || s_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_held_reg <= 1'b0;
            hn_valid_reg  <= 1'b0;
            hn_reg        <= 4'h0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                zero_held_reg <= zero_held_next;
                hn_valid_reg  <= hn_valid_next;
                hn_reg        <= hn_next;
                halted_reg    <= halted_next;
                out_valid_reg <= emit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            out_byte_reg <= byte_val;
            out_has_reg  <= got;
            out_bad_reg  <= bad;
            out_done_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_bad_reg, out_has_reg};
    assign m_tlast  = out_done_reg;

    // after an error nothing may be pending
    a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (!zero_held_reg && !hn_valid_reg))
        else $error("halted with pending digit state");

    // the last character always leaves the parser rearmed
    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=>
            (!zero_held_reg && !hn_valid_reg && !halted_reg && hn_reg == 4'h0))
        else $error("parser not rearmed after last character");

    // every transaction carries a byte, an error or the end mark
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] || m_tuser[1] || m_tlast))
        else $error("empty result transaction");

    // byte value reads zero when no byte is carried
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00))
        else $error("byte value set without a byte");

    // nibble register is cleared whenever no nibble is pending
    a_nibble_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !hn_valid_reg |-> (hn_reg == 4'h0))
        else $error("stale high nibble");

endmodule
